/* src/tsa_pkg.sv */
// Shared types and constants for the triangle stiffness assembly block.
`timescale 1ns / 1ps
package tsa_pkg;

  localparam int CoordW = 18;
  localparam int NodeW = 9;
  localparam int EntryW = 32;
  localparam int DiffW = 19;
  localparam int NumW = 40;
  localparam int DenW = 40;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic signed [EntryW-1:0] ENT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [EntryW-1:0] ENT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic             func;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
    logic [NodeW-1:0] node_c;
    logic signed [CoordW-1:0] xa;
    logic signed [CoordW-1:0] ya;
    logic signed [CoordW-1:0] xb;
    logic signed [CoordW-1:0] yb;
    logic signed [CoordW-1:0] xc;
    logic signed [CoordW-1:0] yc;
    logic [NodeW-1:0] read_row;
    logic [NodeW-1:0] read_col;
  } item_t;

  typedef struct packed {
    logic signed [EntryW-1:0] entry_value;
    logic                     area_error;
    logic                     saturated;
  } result_t;

endpackage

/* src/triangle_stiffness_assembly.sv */
// Top level of the triangle stiffness assembly block.
`timescale 1ns / 1ps
// Usage: items enter on the in_ stream; in_tuser carries func, where 0 adds
// one triangle element into the stiffness matrix and 1 reads one entry.
// Every item yields exactly one transfer on the out_ stream.
// A read passes the read states only; a triangle with non-positive area,
// or with a node index out of range, goes to out_ without an update.
// An add works the nine element entries in turn: it forms the numerator,
// runs the restoring divider and then does a read-modify-write of the
// matrix entry.
// The back end takes the next item in the cycle after a result transfer,
// so it works on one item at a time.
// A two-entry queue in front lets the sender hand over items while the
// back end is busy or the receiver is stalling.
// After reset the matrix memory is cleared one entry a cycle; items wait
// in the queue until it is done.
// When out_tready is low the result holds and no further item is worked.
module triangle_stiffness_assembly
  import tsa_pkg::*;
#(
  parameter int MAX_NODES = 512,
  parameter int ENTRY_FRAC_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func
  input  logic         in_tuser,
  // node_a, node_b, node_c, xa, ya, xb, yb, xc, yc, read_row, read_col
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // entry_value, area_error, saturated
  output logic [39:0]  out_tdata
);

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_ready;

  assign in_item.func = in_tuser;
  assign in_item.node_a = in_tdata[8:0];
  assign in_item.node_b = in_tdata[17:9];
  assign in_item.node_c = in_tdata[26:18];
  assign in_item.xa = in_tdata[44:27];
  assign in_item.ya = in_tdata[62:45];
  assign in_item.xb = in_tdata[80:63];
  assign in_item.yb = in_tdata[98:81];
  assign in_item.xc = in_tdata[116:99];
  assign in_item.yc = in_tdata[134:117];
  assign in_item.read_row = in_tdata[143:135];
  assign in_item.read_col = in_tdata[152:144];

  assign out_tdata = {6'd0, res.saturated, res.area_error, res.entry_value};

  tsa_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  tsa_back #(.MAX_NODES(MAX_NODES), .FRAC(ENTRY_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_item(q_item), .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

endmodule

/* src/tsa_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/tsa_front.sv */
// Front part: accepts items into a short queue.
`timescale 1ns / 1ps
module tsa_front
  import tsa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);

  item_t      buf_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = buf_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* src/tsa_divider.sv */
// Restoring divider for the rounded, scaled element ratio.
`timescale 1ns / 1ps
module tsa_divider
  import tsa_pkg::*;
#(
  parameter int FRAC = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [NumW-1:0]   num,
  input  logic [DenW-1:0]          den,
  output logic                     done,
  output logic signed [EntryW-1:0] quot,
  output logic                     clip
);

  localparam int QW = NumW + FRAC + 2;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]   dvd_r, dvd_nxt;
  logic [QW-1:0]   q_r, q_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r;
  logic            neg_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r;
  logic [DenW:0]   sh;
  logic [QW-1:0]   mag;

  always_comb begin
    sh = {rem_r[DenW-1:0], dvd_r[QW-1]};
    dvd_nxt = dvd_r << 1;
    if (sh >= {1'b0, den_r}) begin
      rem_nxt = sh - {1'b0, den_r};
      q_nxt = {q_r[QW-2:0], 1'b1};
    end else begin
      rem_nxt = sh;
      q_nxt = {q_r[QW-2:0], 1'b0};
    end
    cnt_nxt = cnt_r - CW'(1);
    mag = (q_r + QW'(1)) >> 1;
    clip = neg_r ? (mag > QW'(64'h8000_0000)) : (mag > QW'(64'h7FFF_FFFF));
    if (clip) begin
      quot = neg_r ? ENT_MIN : ENT_MAX;
    end else begin
      quot = neg_r ? -$signed(mag[EntryW-1:0]) : $signed(mag[EntryW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done <= 1'b0;
      cnt_r <= CW'(QW);
      neg_r <= num[NumW-1];
      dvd_r <= {(num[NumW-1] ? QW'(-num) : QW'(num))} << (FRAC + 1);
      den_r <= den;
      rem_r <= '0;
      q_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      q_r <= q_nxt;
      cnt_r <= cnt_nxt;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

/* src/tsa_back.sv */
// Back part: clears the store after reset, computes the element matrix and updates the store, or reads one entry.
`timescale 1ns / 1ps
module tsa_back
  import tsa_pkg::*;
#(
  parameter int MAX_NODES = 512,
  parameter int FRAC = 24
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_ready,
  input  item_t   q_item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int AW = $clog2(MAX_NODES * MAX_NODES);
  localparam int PW = 2 * DiffW;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_D1 = 4'd2, S_D2 = 4'd3,
    S_NUM = 4'd4, S_DIV = 4'd5, S_RD = 4'd6, S_WAIT = 4'd7, S_WR = 4'd8,
    S_RDR = 4'd9, S_RDW = 4'd10, S_OUT = 4'd11;

  logic [3:0] st_r, st_nxt;
  item_t      it_r;
  logic signed [DiffW-1:0] b_r [3];
  logic signed [DiffW-1:0] c_r [3];
  logic signed [2*DiffW+1:0] p_r [3];
  logic signed [PW-1:0] bb, cc;
  logic signed [NumW-1:0] num;
  logic [1:0] i_r, j_r;
  logic       clipf_r;
  logic [AW-1:0] clr_r;
  logic signed [EntryW-1:0] k_r;
  logic       div_start, div_done, div_clip;
  logic signed [EntryW-1:0] div_q;
  logic       we;
  logic [AW-1:0] addr;
  logic [EntryW-1:0] wdata, rdata;
  logic [NodeW-1:0] ni, nj;
  logic signed [EntryW:0] sum;
  logic signed [2*DiffW+1:0] dd;
  logic [DenW-1:0] den_r;
  logic       nodes_ok, rd_ok;

  tsa_ram #(.WIDTH(EntryW), .DEPTH(MAX_NODES * MAX_NODES)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  tsa_divider #(.FRAC(FRAC)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num), .den(den_r),
    .done(div_done), .quot(div_q), .clip(div_clip)
  );

  function automatic logic [NodeW-1:0] pick(input item_t t, input logic [1:0] s);
    case (s)
      2'd0: pick = t.node_a;
      2'd1: pick = t.node_b;
      default: pick = t.node_c;
    endcase
  endfunction

  assign ni = pick(it_r, i_r);
  assign nj = pick(it_r, j_r);
  assign nodes_ok = (32'(it_r.node_a) < MAX_NODES) && (32'(it_r.node_b) < MAX_NODES)
    && (32'(it_r.node_c) < MAX_NODES);
  assign rd_ok = (32'(it_r.read_row) < MAX_NODES) && (32'(it_r.read_col) < MAX_NODES);
  assign dd = p_r[0] + p_r[1] + p_r[2];
  assign bb = PW'(b_r[i_r]) * PW'(b_r[j_r]);
  assign cc = PW'(c_r[i_r]) * PW'(c_r[j_r]);
  assign num = NumW'(bb) + NumW'(cc);
  assign sum = EntryW'(0) + $signed(rdata) + k_r;
  assign q_ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);
  assign div_start = (st_r == S_NUM);

  always_comb begin
    we = 1'b0;
    addr = AW'(ni) * AW'(MAX_NODES) + AW'(nj);
    wdata = sum[EntryW-1:0];
    if (st_r == S_CLEAR) begin
      we = 1'b1;
      addr = clr_r;
      wdata = '0;
    end else if (st_r == S_RDR || st_r == S_RDW) begin
      addr = AW'(it_r.read_row) * AW'(MAX_NODES) + AW'(it_r.read_col);
    end else if (st_r == S_WR) begin
      we = 1'b1;
      if (sum > $signed({1'b0, ENT_MAX})) begin
        wdata = ENT_MAX;
      end else if (sum < $signed({1'b1, ENT_MIN})) begin
        wdata = ENT_MIN;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLEAR: if (clr_r == AW'(MAX_NODES * MAX_NODES - 1)) st_nxt = S_IDLE;
      S_IDLE: if (q_valid) st_nxt = (q_item.func == FUNC_READ) ? S_RDR : S_D1;
      S_D1: st_nxt = nodes_ok ? S_D2 : S_OUT;
      S_D2: st_nxt = (dd <= 0) ? S_OUT : S_NUM;
      S_NUM: st_nxt = S_DIV;
      S_DIV: if (div_done) st_nxt = S_RD;
      S_RD: st_nxt = S_WAIT;
      S_WAIT: st_nxt = S_WR;
      S_WR: st_nxt = (i_r == 2'd2 && j_r == 2'd2) ? S_OUT : S_NUM;
      S_RDR: st_nxt = S_RDW;
      S_RDW: st_nxt = S_OUT;
      S_OUT: if (res_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLEAR) clr_r <= clr_r + AW'(1);
      case (st_r)
        S_IDLE: if (q_valid) begin
          it_r <= q_item;
          res <= '0;
          i_r <= 2'd0;
          j_r <= 2'd0;
          clipf_r <= 1'b0;
        end
        S_D1: begin
          b_r[0] <= DiffW'(it_r.yb) - DiffW'(it_r.yc);
          b_r[1] <= DiffW'(it_r.yc) - DiffW'(it_r.ya);
          b_r[2] <= DiffW'(it_r.ya) - DiffW'(it_r.yb);
          c_r[0] <= DiffW'(it_r.xc) - DiffW'(it_r.xb);
          c_r[1] <= DiffW'(it_r.xa) - DiffW'(it_r.xc);
          c_r[2] <= DiffW'(it_r.xb) - DiffW'(it_r.xa);
          p_r[0] <= it_r.xa * (DiffW'(it_r.yb) - DiffW'(it_r.yc));
          p_r[1] <= it_r.xb * (DiffW'(it_r.yc) - DiffW'(it_r.ya));
          p_r[2] <= it_r.xc * (DiffW'(it_r.ya) - DiffW'(it_r.yb));
        end
        S_D2: begin
          den_r <= DenW'(dd) << 1;
          if (dd <= 0) res.area_error <= 1'b1;
        end
        S_DIV: if (div_done) begin
          k_r <= div_q;
          if (div_clip) clipf_r <= 1'b1;
        end
        S_WR: begin
          if (sum > $signed({1'b0, ENT_MAX}) || sum < $signed({1'b1, ENT_MIN})) begin
            clipf_r <= 1'b1;
            res.saturated <= 1'b1;
          end else begin
            res.saturated <= clipf_r;
          end
          if (j_r == 2'd2) begin
            j_r <= 2'd0;
            i_r <= i_r + 2'd1;
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        S_RDW: res.entry_value <= rd_ok ? $signed(rdata) : '0;
        default: ;
      endcase
    end
  end

endmodule
